>>> src/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner assertion failed");

`endif

>>> src/scls_pkg.sv
// Constants, phase codes and helper functions of the leak scanner.
package scls_pkg;

    localparam int DEFAULT_WINDOW_BYTES = 8;
    localparam int DEFAULT_COUNT_BITS   = 16;

    localparam int LIMIT_BITS = 16;
    localparam logic [LIMIT_BITS-1:0] CURLY_LIMIT_RESET = 16'd2;
    localparam logic [LIMIT_BITS-1:0] TOTAL_LIMIT_RESET = 16'd5;

    localparam logic [1:0] REG_CURLY_LIMIT = 2'd0;
    localparam logic [1:0] REG_TOTAL_LIMIT = 2'd1;

    localparam logic [3:0] RULE_NONE     = 4'd0;
    localparam logic [3:0] RULE_BRACKETS = 4'd1;
    localparam logic [3:0] RULE_CALL     = 4'd2;
    localparam logic [3:0] RULE_OPERATOR = 4'd3;
    localparam logic [3:0] RULE_KEYWORD  = 4'd4;
    localparam logic [3:0] RULE_COMMENT  = 4'd5;
    localparam logic [3:0] RULE_MEMBER   = 4'd6;
    localparam logic [3:0] RULE_MAIN     = 4'd7;
    localparam logic [3:0] RULE_IF       = 4'd8;
    localparam logic [3:0] RULE_WHILE    = 4'd9;
    localparam logic [3:0] RULE_FOR      = 4'd10;

    typedef logic [3:0] phase_t;
    localparam phase_t PH_SEARCH = 4'd0;
    localparam phase_t PH_VERIFY = 4'd1;
    localparam phase_t PH_SKIP   = 4'd2;
    localparam phase_t PH_SEMI1  = 4'd3;
    localparam phase_t PH_SEMI2  = 4'd4;
    localparam phase_t PH_CLOSEP = 4'd5;
    localparam phase_t PH_SKIP2  = 4'd6;
    localparam phase_t PH_CLOSEC = 4'd7;
    localparam phase_t PH_YES    = 4'd8;
    localparam phase_t PH_NO     = 4'd9;
    localparam phase_t PH_OPENC  = 4'd10;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LSQ    = 8'h5B;
    localparam logic [7:0] CH_RSQ    = 8'h5D;
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_RCURLY = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_Q      = 8'h51;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    // if / while / for tracker; hit = whole word just ended
    function automatic phase_t word_next(input phase_t ph, input logic [7:0] c,
                                         input logic hit, input logic semis);
        phase_t r;
        r = PH_NO;
        unique case (ph)
            PH_VERIFY: begin
                if (c == CH_SPACE) r = PH_SKIP;
                else if (c == CH_LPAREN) r = semis ? PH_SEMI1 : PH_CLOSEP;
                else if (is_ws(c)) r = PH_NO;
                else r = hit ? PH_VERIFY : PH_SEARCH;
            end
            PH_SEARCH: r = hit ? PH_VERIFY : PH_SEARCH;
            PH_SKIP: begin
                if (c == CH_SPACE) r = PH_SKIP;
                else if (c == CH_LPAREN) r = semis ? PH_SEMI1 : PH_CLOSEP;
                else r = PH_NO;
            end
            PH_SEMI1:  r = (c == CH_SEMI) ? PH_SEMI2 : ph;
            PH_SEMI2:  r = (c == CH_SEMI) ? PH_CLOSEP : ph;
            PH_CLOSEP: r = (c == CH_RPAREN) ? PH_SKIP2 : ph;
            PH_SKIP2: begin
                if (c == CH_SPACE) r = PH_SKIP2;
                else r = (c == CH_LCURLY) ? PH_CLOSEC : PH_NO;
            end
            PH_CLOSEC: r = (c == CH_RCURLY) ? PH_YES : ph;
            PH_YES:    r = PH_YES;
            default:   r = PH_NO;
        endcase
        return r;
    endfunction

    // main tracker; hit = "main" just ended, cand = int run seen before it
    function automatic phase_t main_next(input phase_t ph, input logic [7:0] c,
                                         input logic hit, input logic cand);
        phase_t r;
        r = PH_NO;
        unique case (ph)
            PH_SEARCH: begin
                if (hit) r = cand ? PH_SKIP : PH_NO;
                else r = PH_SEARCH;
            end
            PH_SKIP: begin
                if (c == CH_SPACE) r = PH_SKIP;
                else r = (c == CH_LPAREN) ? PH_CLOSEP : PH_NO;
            end
            PH_CLOSEP: r = (c == CH_RPAREN) ? PH_OPENC : ph;
            PH_OPENC:  r = (c == CH_LCURLY) ? PH_CLOSEC : ph;
            PH_CLOSEC: r = (c == CH_RCURLY) ? PH_YES : ph;
            PH_YES:    r = PH_YES;
            default:   r = PH_NO;
        endcase
        return r;
    endfunction

endpackage

>>> src/source_code_leak_scanner_unit.sv
// Leak scanner top level: byte stream in, one verdict per terminator request out.
//   channel | ports                                | moves
//   in      | s_valid s_ready s_char_byte s_end_of_text | one text byte or terminator
//   out     | m_valid m_ready m_leak_found m_rule_code  | verdict per terminator
//   cfg     | cfg_we cfg_index cfg_data             | limit register writes
// One request per cycle while s_ready is high; each byte updates match state when taken.
// A terminator loads the verdict register at its accepting edge and clears the match state;
// m_valid is high from the next cycle on.
// The input stalls only while a verdict waits in the output register and m_ready is low.
// Synchronous active-low reset clears match state and output valid and reloads the limits.
module source_code_leak_scanner_unit #(
    parameter int WINDOW_BYTES = scls_pkg::DEFAULT_WINDOW_BYTES,
    parameter int COUNT_BITS   = scls_pkg::DEFAULT_COUNT_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_char_byte,
    input  logic                            s_end_of_text,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_leak_found,
    output logic [3:0]                      m_rule_code,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [scls_pkg::LIMIT_BITS-1:0] cfg_data
);
    import scls_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [LIMIT_BITS-1:0] curly_limit_reg, total_limit_reg;

    logic [7:0] win_reg [WINDOW_BYTES];
    logic [7:0] win_next [WINDOW_BYTES];
    logic [COUNT_BITS-1:0] seen_reg, seen_next;
    logic [COUNT_BITS-1:0] bal_reg [3];
    logic [COUNT_BITS-1:0] bal_next [3];
    logic [COUNT_BITS-1:0] curly_cnt_reg, curly_cnt_next, open_cnt_reg, open_cnt_next;
    logic cancel_reg, cancel_next;
    logic call_done_reg, call_hit_reg, oper_reg, kw_reg, copen_reg, cclose_reg;
    logic member_reg, gt_reg, gt_prev_reg;
    logic call_done_next, call_hit_next, oper_next, kw_next, copen_next, cclose_next;
    logic member_next, gt_next, gt_prev_next;
    logic [3:0] hist_reg, hist_next;
    logic [23:0] lnc_reg, lnc_next;
    logic [1:0] nbc_reg, nbc_next;
    phase_t ph_reg [4];
    phase_t ph_next [4];

    logic m_valid_reg, leak_reg;
    logic [3:0] rule_reg, rule_next;

    logic accept, is_open, is_close, cand;
    logic hit_main, hit_if, hit_while, hit_for;
    logic [1:0] kind;
    logic [7:0] c;

    assign s_ready      = !m_valid_reg || m_ready;
    assign accept       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_leak_found = leak_reg;
    assign m_rule_code  = rule_reg;
    assign c            = s_char_byte;

    always_comb begin
        win_next[0] = c;
        for (int k = 1; k < WINDOW_BYTES; k++) win_next[k] = win_reg[k-1];
        seen_next = (seen_reg == CNT_MAX) ? seen_reg : seen_reg + 1'b1;

        // brackets
        is_open  = 1'b0;
        is_close = 1'b0;
        kind     = 2'd0;
        case (c)
            CH_LPAREN: begin is_open = 1'b1;  kind = 2'd0; end
            CH_RPAREN: begin is_close = 1'b1; kind = 2'd0; end
            CH_LSQ:    begin is_open = 1'b1;  kind = 2'd1; end
            CH_RSQ:    begin is_close = 1'b1; kind = 2'd1; end
            CH_LCURLY: begin is_open = 1'b1;  kind = 2'd2; end
            CH_RCURLY: begin is_close = 1'b1; kind = 2'd2; end
            default: ;
        endcase
        for (int k = 0; k < 3; k++) bal_next[k] = bal_reg[k];
        curly_cnt_next = curly_cnt_reg;
        open_cnt_next  = open_cnt_reg;
        cancel_next    = cancel_reg;
        if (is_open) begin
            if (bal_reg[kind] != CNT_MAX) bal_next[kind] = bal_reg[kind] + 1'b1;
            if (open_cnt_reg != CNT_MAX) open_cnt_next = open_cnt_reg + 1'b1;
            if (kind == 2'd2 && curly_cnt_reg != CNT_MAX)
                curly_cnt_next = curly_cnt_reg + 1'b1;
        end else if (is_close) begin
            if (bal_reg[kind] == '0) cancel_next = 1'b1;
            else bal_next[kind] = bal_reg[kind] - 1'b1;
        end

        // simple patterns
        call_done_next = call_done_reg;
        call_hit_next  = call_hit_reg;
        if (!call_done_reg && c == CH_RPAREN && win_next[1] == CH_LPAREN) begin
            call_done_next = 1'b1;
            if (is_letter(win_next[2])) call_hit_next = 1'b1;
        end
        oper_next = oper_reg
            || (win_next[1] == CH_AMP && c == CH_AMP)
            || (win_next[1] == CH_EQ && c == CH_EQ);
        kw_next = kw_reg
            || (win_next[4] == "c" && win_next[3] == "h" && win_next[2] == "a"
                && win_next[1] == "r" && c == CH_STAR)
            || (win_next[5] == "c" && win_next[4] == "h" && win_next[3] == "a"
                && win_next[2] == "r" && win_next[1] == CH_SPACE && c == CH_STAR)
            || (win_next[6] == "#" && win_next[5] == "d" && win_next[4] == "e"
                && win_next[3] == "f" && win_next[2] == "i" && win_next[1] == "n"
                && c == "e")
            || (win_next[7] == "#" && win_next[6] == "i" && win_next[5] == "n"
                && win_next[4] == "c" && win_next[3] == "l" && win_next[2] == "u"
                && win_next[1] == "d" && c == "e");
        copen_next  = copen_reg || (win_next[1] == CH_SLASH && c == CH_STAR);
        cclose_next = cclose_reg || (win_next[1] == CH_STAR && c == CH_SLASH);
        member_next = member_reg || (gt_prev_reg && win_next[1] == CH_DOT
            && is_letter(win_next[2]) && is_letter(c) && c != CH_Q);
        gt_prev_next = gt_reg;
        gt_next      = gt_reg || (c == CH_GT);

        // main candidate tracking
        cand = is_ws(win_next[1]) && nbc_reg == 2'd3 && lnc_reg == {"i", "n", "t"};
        hist_next = {hist_reg[2:0], cand};
        lnc_next  = lnc_reg;
        nbc_next  = nbc_reg;
        if (!is_ws(c)) begin
            lnc_next = {win_next[2], win_next[1], c};
            nbc_next = (seen_next >= COUNT_BITS'(3)) ? 2'd3 : seen_next[1:0];
        end

        hit_main  = win_next[3] == "m" && win_next[2] == "a" && win_next[1] == "i"
            && c == "n";
        hit_if    = win_next[1] == "i" && c == "f"
            && (seen_next == COUNT_BITS'(2) || is_ws(win_next[2]));
        hit_for   = win_next[2] == "f" && win_next[1] == "o" && c == "r"
            && (seen_next == COUNT_BITS'(3) || is_ws(win_next[3]));
        hit_while = win_next[4] == "w" && win_next[3] == "h" && win_next[2] == "i"
            && win_next[1] == "l" && c == "e"
            && (seen_next == COUNT_BITS'(5) || is_ws(win_next[5]));
        ph_next[0] = main_next(ph_reg[0], c, hit_main, hist_next[3]);
        ph_next[1] = word_next(ph_reg[1], c, hit_if, 1'b0);
        ph_next[2] = word_next(ph_reg[2], c, hit_while, 1'b0);
        ph_next[3] = word_next(ph_reg[3], c, hit_for, 1'b1);

        // verdict from stored state
        if (!cancel_reg && (32'(curly_cnt_reg) > 32'(curly_limit_reg)
                            || 32'(open_cnt_reg) > 32'(total_limit_reg)))
            rule_next = RULE_BRACKETS;
        else if (call_hit_reg)          rule_next = RULE_CALL;
        else if (oper_reg)              rule_next = RULE_OPERATOR;
        else if (kw_reg)                rule_next = RULE_KEYWORD;
        else if (copen_reg && cclose_reg) rule_next = RULE_COMMENT;
        else if (member_reg)            rule_next = RULE_MEMBER;
        else if (ph_reg[0] == PH_YES)   rule_next = RULE_MAIN;
        else if (ph_reg[1] == PH_YES)   rule_next = RULE_IF;
        else if (ph_reg[2] == PH_YES)   rule_next = RULE_WHILE;
        else if (ph_reg[3] == PH_YES)   rule_next = RULE_FOR;
        else                            rule_next = RULE_NONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curly_limit_reg <= CURLY_LIMIT_RESET;
            total_limit_reg <= TOTAL_LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CURLY_LIMIT: curly_limit_reg <= cfg_data;
                REG_TOTAL_LIMIT: total_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_end_of_text)) begin
            for (int k = 0; k < WINDOW_BYTES; k++) win_reg[k] <= '0;
            for (int k = 0; k < 3; k++) bal_reg[k] <= '0;
            for (int k = 0; k < 4; k++) ph_reg[k] <= PH_SEARCH;
            seen_reg      <= '0;
            curly_cnt_reg <= '0;
            open_cnt_reg  <= '0;
            cancel_reg    <= 1'b0;
            call_done_reg <= 1'b0;
            call_hit_reg  <= 1'b0;
            oper_reg      <= 1'b0;
            kw_reg        <= 1'b0;
            copen_reg     <= 1'b0;
            cclose_reg    <= 1'b0;
            member_reg    <= 1'b0;
            gt_reg        <= 1'b0;
            gt_prev_reg   <= 1'b0;
            hist_reg      <= '0;
            lnc_reg       <= '0;
            nbc_reg       <= '0;
        end else if (accept) begin
            win_reg       <= win_next;
            bal_reg       <= bal_next;
            ph_reg        <= ph_next;
            seen_reg      <= seen_next;
            curly_cnt_reg <= curly_cnt_next;
            open_cnt_reg  <= open_cnt_next;
            cancel_reg    <= cancel_next;
            call_done_reg <= call_done_next;
            call_hit_reg  <= call_hit_next;
            oper_reg      <= oper_next;
            kw_reg        <= kw_next;
            copen_reg     <= copen_next;
            cclose_reg    <= cclose_next;
            member_reg    <= member_next;
            gt_reg        <= gt_next;
            gt_prev_reg   <= gt_prev_next;
            hist_reg      <= hist_next;
            lnc_reg       <= lnc_next;
            nbc_reg       <= nbc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && s_end_of_text) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_end_of_text) begin
            leak_reg <= (rule_next != RULE_NONE);
            rule_reg <= rule_next;
        end
    end

endmodule

>>> src/scls_checker.sv
// Port-level checker for the leak scanner, bound to the top level.
`include "assert_macros.svh"

module scls_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_end_of_text,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_leak_found,
    input logic [3:0] m_rule_code
);
    import scls_pkg::*;

    `ASSERT_NEXT(a_term_gives_verdict, aclk, aresetn, s_valid && s_ready && s_end_of_text, m_valid)
    `ASSERT_IMPL(a_leak_matches_rule, aclk, aresetn, m_valid, m_leak_found == (m_rule_code != RULE_NONE))
    `ASSERT_IMPL(a_rule_in_range, aclk, aresetn, m_valid, m_rule_code <= RULE_FOR)
    `ASSERT_NEXT(a_out_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_rule_code))

endmodule

bind source_code_leak_scanner_unit scls_checker u_scls_checker (.*);

>>> tb/source_code_leak_scanner_unit_tb.sv
// Self-checking testbench for the leak scanner: text streams with a predicted verdict each.
`timescale 1ns / 1ps

module source_code_leak_scanner_unit_tb;
    import scls_pkg::*;

    localparam int WIN = 8;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;
    localparam int IDLE_LIMIT = 20000;

    class verdict_board;
        logic [15:0] curly_lim, total_lim;
        logic [7:0]  win [WIN];
        logic [15:0] nbytes;
        logic [15:0] bal [3];
        logic [15:0] n_curly, n_open;
        logic        cancelled;
        logic        call_done, call_hit, oper, kword, c_open, c_close, member, gt_seen;
        logic        gt_prev;
        logic [3:0]  cand_hist;
        phase_t      ph [4];
        logic [23:0] last3;
        logic [1:0]  nlast;
        logic [3:0]  pending_rule [$];
        int          errors;

        function void clear();
            foreach (win[k]) win[k] = 8'd0;
            nbytes = 0;
            foreach (bal[k]) bal[k] = 0;
            n_curly = 0;
            n_open = 0;
            cancelled = 0;
            {call_done, call_hit, oper, kword, c_open, c_close, member, gt_seen} = '0;
            gt_prev = 0;
            cand_hist = 0;
            foreach (ph[k]) ph[k] = PH_SEARCH;
            last3 = 0;
            nlast = 0;
        endfunction

        function void init();
            curly_lim = 16'd2;
            total_lim = 16'd5;
            errors = 0;
            clear();
        endfunction

        function logic [7:0] prior(int k);
            if (k >= WIN || k >= nbytes) return 8'd0;
            return win[k];
        endfunction

        function logic tail_is(string s);
            int n;
            n = s.len();
            if (n > nbytes || n > WIN) return 0;
            for (int k = 0; k < n; k++)
                if (prior(n - 1 - k) != s[k]) return 0;
            return 1;
        endfunction

        function logic ws(logic [7:0] c);
            return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function logic alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function logic [15:0] inc(logic [15:0] v);
            return v < CNT_MAX ? v + 16'd1 : v;
        endfunction

        function phase_t track_word(phase_t p, logic [7:0] c, string w, logic semis);
            logic hit;
            hit = tail_is(w) && (nbytes == w.len() || ws(prior(w.len())));
            case (p)
                PH_VERIFY: begin
                    if (c == " ") return PH_SKIP;
                    if (c == "(") return semis ? PH_SEMI1 : PH_CLOSEP;
                    if (ws(c)) return PH_NO;
                    return hit ? PH_VERIFY : PH_SEARCH;
                end
                PH_SEARCH: return hit ? PH_VERIFY : PH_SEARCH;
                PH_SKIP: begin
                    if (c == " ") return PH_SKIP;
                    if (c == "(") return semis ? PH_SEMI1 : PH_CLOSEP;
                    return PH_NO;
                end
                PH_SEMI1: return c == ";" ? PH_SEMI2 : p;
                PH_SEMI2: return c == ";" ? PH_CLOSEP : p;
                PH_CLOSEP: return c == ")" ? PH_SKIP2 : p;
                PH_SKIP2: begin
                    if (c == " ") return PH_SKIP2;
                    return c == "{" ? PH_CLOSEC : PH_NO;
                end
                PH_CLOSEC: return c == "}" ? PH_YES : p;
                PH_YES: return PH_YES;
                default: return PH_NO;
            endcase
        endfunction

        function phase_t track_main(phase_t p, logic [7:0] c);
            case (p)
                PH_SEARCH: begin
                    if (tail_is("main")) return cand_hist[3] ? PH_SKIP : PH_NO;
                    return PH_SEARCH;
                end
                PH_SKIP: begin
                    if (c == " ") return PH_SKIP;
                    return c == "(" ? PH_CLOSEP : PH_NO;
                end
                PH_CLOSEP: return c == ")" ? PH_OPENC : p;
                PH_OPENC: return c == "{" ? PH_CLOSEC : p;
                PH_CLOSEC: return c == "}" ? PH_YES : p;
                PH_YES: return PH_YES;
                default: return PH_NO;
            endcase
        endfunction

        function void take(logic [7:0] c);
            int kind;
            logic opener, cand;
            for (int k = WIN - 1; k > 0; k--) win[k] = win[k-1];
            win[0] = c;
            nbytes = inc(nbytes);
            kind = -1;
            opener = 0;
            case (c)
                "(": begin kind = 0; opener = 1; end
                ")": kind = 0;
                "[": begin kind = 1; opener = 1; end
                "]": kind = 1;
                "{": begin kind = 2; opener = 1; end
                "}": kind = 2;
                default: ;
            endcase
            if (kind >= 0) begin
                if (opener) begin
                    bal[kind] = inc(bal[kind]);
                    n_open = inc(n_open);
                    if (kind == 2) n_curly = inc(n_curly);
                end else if (bal[kind] == 0) begin
                    cancelled = 1;
                end else begin
                    bal[kind] = bal[kind] - 1;
                end
            end
            if (!call_done && c == ")" && prior(1) == "(") begin
                call_done = 1;
                if (alpha(prior(2))) call_hit = 1;
            end
            if (tail_is("&&") || tail_is("==")) oper = 1;
            if (tail_is("char*") || tail_is("char *") || tail_is("#define")
                || tail_is("#include")) kword = 1;
            if (tail_is("/*")) c_open = 1;
            if (tail_is("*/")) c_close = 1;
            if (gt_prev && prior(1) == "." && alpha(prior(2)) && alpha(c) && c != "Q")
                member = 1;
            gt_prev = gt_seen;
            if (c == ">") gt_seen = 1;
            cand = ws(prior(1)) && nlast == 2'd3 && last3 == {"i", "n", "t"};
            cand_hist = {cand_hist[2:0], cand};
            if (!ws(c)) begin
                last3 = {prior(2), prior(1), c};
                nlast = nbytes >= 3 ? 2'd3 : nbytes[1:0];
            end
            ph[0] = track_main(ph[0], c);
            ph[1] = track_word(ph[1], c, "if", 0);
            ph[2] = track_word(ph[2], c, "while", 0);
            ph[3] = track_word(ph[3], c, "for", 1);
        endfunction

        function logic [3:0] judge();
            if (!cancelled && (n_curly > curly_lim || n_open > total_lim)) return RULE_BRACKETS;
            if (call_hit) return RULE_CALL;
            if (oper) return RULE_OPERATOR;
            if (kword) return RULE_KEYWORD;
            if (c_open && c_close) return RULE_COMMENT;
            if (member) return RULE_MEMBER;
            if (ph[0] == PH_YES) return RULE_MAIN;
            if (ph[1] == PH_YES) return RULE_IF;
            if (ph[2] == PH_YES) return RULE_WHILE;
            if (ph[3] == PH_YES) return RULE_FOR;
            return RULE_NONE;
        endfunction

        function void note_request(logic [7:0] c, logic eot);
            if (!eot) begin
                take(c);
            end else begin
                pending_rule.push_back(judge());
                clear();
            end
        endfunction

        function void set_limit(logic [1:0] idx, logic [15:0] v);
            if (idx == REG_CURLY_LIMIT) curly_lim = v;
            else if (idx == REG_TOTAL_LIMIT) total_lim = v;
        endfunction

        task report(string what, int want, int got);
            errors++;
            $display("mismatch %s: expected %0d got %0d", what, want, got);
        endtask

        task check_verdict(logic leak, logic [3:0] rule);
            logic [3:0] want;
            if (pending_rule.size() == 0) begin
                report("verdict with none pending", 0, rule);
                return;
            end
            want = pending_rule.pop_front();
            if (leak !== (want != RULE_NONE)) report("leak_found", want != RULE_NONE, leak);
            if (rule !== want) report("rule_code", want, rule);
        endtask
    endclass

    logic        aclk, aresetn;
    logic        s_valid, s_ready, s_end_of_text;
    logic [7:0]  s_char_byte;
    logic        m_valid, m_ready, m_leak_found;
    logic [3:0]  m_rule_code;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    verdict_board board;
    int idle_cycles;
    logic phase_quiet;

    source_code_leak_scanner_unit uut (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_request(s_char_byte, s_end_of_text);
            if (m_valid && m_ready) board.check_verdict(m_leak_found, m_rule_code);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("source_code_leak_scanner_unit_tb failed");
                $finish;
            end
        end
    end

    initial begin
        m_ready = 0;
        @(negedge aclk);
        forever begin
            int g;
            g = gap_len();
            m_ready = g == 0 ? 1'b1 : 1'b0;
            repeat (g == 0 ? $urandom_range(1, 6) : g) @(negedge aclk);
        end
    end

    task automatic send(logic [7:0] c, logic eot);
        int g;
        g = (phase_quiet) ? 0 : gap_len();
        repeat (g) @(negedge aclk);
        s_valid = 1;
        s_char_byte = c;
        s_end_of_text = eot;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid = 0;
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++) send(s[k], 0);
        send(8'($urandom), 1);
    endtask

    task automatic drain();
        while (board.pending_rule.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_limit(logic [1:0] idx, logic [15:0] v);
        drain();
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = v;
        board.set_limit(idx, v);
        @(negedge aclk);
        cfg_we = 0;
    endtask

    string frags [] = '{"int main() { }", "if (x) {y}", "while (a) { }", "for (i;j;) {}",
                        "f()", "a&&b", "x==y", "char *p", "char*q", "#define", "#include",
                        "/* c */", "p>q a.b", "a.Q", "{{{", "((([[", ")(", " ", "\t", "\n",
                        "int\tmain (){}", "if(", "for (;;) {}", "iff (x) {}", "main", "x"};

    task automatic random_text(int n);
        string s;
        int r;
        s = "";
        while (s.len() < n) begin
            r = $urandom_range(0, 9);
            if (r < 6) s = {s, frags[$urandom_range(0, frags.size() - 1)]};
            else if (r < 8) s = {s, string'(byte'($urandom_range(32, 126)))};
            else s = {s, string'(byte'($urandom_range(0, 255)))};
        end
        for (int k = 0; k < s.len(); k++) send(s[k], 0);
        if ($urandom_range(0, 15) == 0)
            for (int k = 0; k < 3; k++) send(8'h00, 0);
        send(8'($urandom), 1);
    endtask

    initial begin
        board = new();
        board.init();
        s_valid = 0;
        s_char_byte = 0;
        s_end_of_text = 0;
        cfg_we = 0;
        cfg_index = REG_CURLY_LIMIT;
        cfg_data = 0;
        phase_quiet = 0;
        idle_cycles = 0;
        aresetn = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        send(8'h00, 1);
        send_text("{{{");
        send_text("((([[[");
        send_text("}{{{");
        send_text("foo()");
        send_text("a && b");
        send_text("a == b");
        send_text("char *p;");
        send_text("#include");
        send_text("/* x */");
        send_text("> a.b");
        send_text("> a.Q");
        send_text("int main() {x}");
        send_text("if (a) {b}");
        send_text("while (a) {b}");
        send_text("for (a;b;c) {d}");
        send_text("\xff\x80 if\t(a)");
        drain();
        write_limit(REG_CURLY_LIMIT, 16'hFFFF);
        write_limit(REG_TOTAL_LIMIT, 16'hFFFF);
        send_text("{{{{{{{{");
        write_limit(REG_CURLY_LIMIT, 16'd0);
        write_limit(REG_TOTAL_LIMIT, 16'd0);
        send_text("(");
        send_text("x");

        for (int ph = 0; ph < 5; ph++) begin
            logic [15:0] lims [2];
            lims[0] = ph == 4 ? 16'd2 : 16'($urandom_range(0, 8));
            lims[1] = ph == 4 ? 16'd5 : 16'($urandom_range(0, 12));
            if (ph == 3) lims[1] = 16'hFFFF;
            write_limit(REG_CURLY_LIMIT, lims[0]);
            write_limit(REG_TOTAL_LIMIT, lims[1]);
            for (int k = 0; k < 12; k++) begin
                random_text($urandom_range(1, 30));
                if (k == 5) begin
                    drain();
                end
            end
            phase_quiet = ph == 2;
        end
        phase_quiet = 0;
        drain();
        repeat (20) @(negedge aclk);
        if (board.errors == 0 && board.pending_rule.size() == 0)
            $display("source_code_leak_scanner_unit_tb passed");
        else
            $display("source_code_leak_scanner_unit_tb failed");
        $finish;
    end
endmodule

>>> sim.f
+incdir+src
src/scls_pkg.sv
src/source_code_leak_scanner_unit.sv
src/scls_checker.sv
tb/source_code_leak_scanner_unit_tb.sv
